// File: design/assert_macros.svh
// Assertion macros shared by the wildcard byte pattern scan RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WBPS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define WBPS_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/wbps_pkg.sv
// Package for the wildcard byte pattern scan: sizes, register indexes, types.
// No dependencies; imported by every module of the block.
package wbps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int OFFSET_BITS       = 32;

	localparam int LEN_W      = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int PAT_IDX_W  = 4;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int LEN_REG_W  = 5;
	localparam int MATCH_W    = 32;
	localparam int WIDE_W     = (OFFSET_BITS > MATCH_W) ? OFFSET_BITS : MATCH_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_PATTERN_LEN  = 3'd2,
		REG_WILDCARD_EN  = 3'd3,
		REG_WILDCARD     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       active;
		logic       care;
		logic [7:0] expect_byte;
	} cell_ctl_t;

	typedef struct packed {
		logic               found;
		logic [MATCH_W-1:0] match_offset;
	} result_t;

	function automatic logic [7:0] pattern_at(input logic [CFG_W-1:0] lo,
			input logic [CFG_W-1:0] hi, input logic [PAT_IDX_W-1:0] idx);
		logic [CFG_W-1:0] w;
		w = idx[3] ? hi : lo;
		return w[{idx[2:0], 3'b000} +: 8];
	endfunction

endpackage

// File: design/wbps_cell.sv
// One window cell: holds one byte of the sliding window and tests the byte
// shifted into it against its pattern byte. Depends on wbps_pkg.
module wbps_cell
	import wbps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] din,
	input  cell_ctl_t  ctl,
	output logic [7:0] dout,
	output logic       hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= clear ? 8'd0 : din;
		end
	end

	assign dout = byte_q;
	assign hit  = !ctl.active || !ctl.care || (din == ctl.expect_byte);

endmodule

// File: design/wbps_out_buf.sv
// Two-word result queue between the scan logic and the master-side stream.
// Depends on wbps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wbps_out_buf
	import wbps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    m_valid,
	input  logic    m_ready,
	output result_t m_data
);

	result_t    slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop     = m_valid && m_ready;
	assign full    = (count_q == 2'd2);
	assign m_valid = (count_q != 2'd0);
	assign m_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`WBPS_NEVER(a_no_overflow, clk, arst_n, push && full && !pop, "result queue overflow")
	`WBPS_NEVER(a_count_range, clk, arst_n, count_q == 2'd3, "result queue count out of range")

endmodule

// File: design/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scan: config registers, position
// counter, chain of window cells, result queue. Depends on wbps_pkg,
// wbps_cell, wbps_out_buf and assert_macros.svh.
//
// Usage: bytes enter on the slave stream, one per word, data in s_tdata[7:0]
// and s_tlast marking the final byte of a region. A chain of window cells,
// one per possible pattern byte, shifts each byte in and compares the window
// against the pattern in the same cycle. The first full-window match gives
// one result word (m_tuser = 1, m_tdata = start offset); a region that ends
// without a match gives one word with m_tuser = 0 and m_tdata = 0. After the
// last byte the window, position and match flag clear for the next region.
// Throughput: one byte per cycle while s_tready is high. A result enters the
// queue when its byte is accepted and reaches the master stream behind any
// older result. A two-word result queue decouples the sides: bytes keep
// flowing while one result waits; s_tready drops only while two results are
// queued. Reset clears window, position, queue and registers (pattern length
// resets to one). Configuration is written by the user through cfg_we,
// cfg_index and cfg_data only while no region is in flight (unenforced).
`include "assert_macros.svh"
module wildcard_byte_pattern_scan
	import wbps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [7:0] data_byte
	input  logic                 s_tlast,  // last_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [MATCH_W-1:0]   m_tdata,  // [31:0] match_offset
	output logic                 m_tuser   // found
);

	logic [CFG_W-1:0]       pat_lo_q;
	logic [CFG_W-1:0]       pat_hi_q;
	logic [LEN_REG_W-1:0]   len_q;
	logic                   wc_en_q;
	logic [7:0]             wc_byte_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   rep_q;

	logic                   accept;
	logic                   q_full;
	logic [LEN_W-1:0]       eff_len;
	logic [OFFSET_BITS-1:0] pos_next;
	logic [OFFSET_BITS-1:0] off_diff;
	logic [WIDE_W-1:0]      off_wide;
	logic                   window_full;
	logic                   found_now;
	logic                   push;
	result_t                push_data;
	result_t                m_data;

	logic [7:0]             cell_q   [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] cell_hit;
	cell_ctl_t              cell_ctl [MAX_PATTERN_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			len_q     <= LEN_REG_W'(1);
			wc_en_q   <= 1'b0;
			wc_byte_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_lo_q  <= cfg_data;
				REG_PATTERN_HIGH: pat_hi_q  <= cfg_data;
				REG_PATTERN_LEN:  len_q     <= cfg_data[LEN_REG_W-1:0];
				REG_WILDCARD_EN:  wc_en_q   <= cfg_data[0];
				REG_WILDCARD:     wc_byte_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (LEN_W'(len_q) > LEN_W'(MAX_PATTERN_BYTES)) begin
			eff_len = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			eff_len = LEN_W'(len_q);
		end
	end

	genvar k;
	generate
		for (k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
			logic [LEN_W:0]     sum;
			logic [PAT_IDX_W-1:0] idx;
			logic [7:0]         pbyte;
			logic [7:0]         din;

			assign sum   = (LEN_W+1)'(k) + (LEN_W+1)'(eff_len);
			assign idx   = PAT_IDX_W'(sum - (LEN_W+1)'(MAX_PATTERN_BYTES));
			assign pbyte = pattern_at(pat_lo_q, pat_hi_q, idx);
			assign cell_ctl[k].active      = (sum >= (LEN_W+1)'(MAX_PATTERN_BYTES));
			assign cell_ctl[k].care        = !(wc_en_q && (pbyte == wc_byte_q));
			assign cell_ctl[k].expect_byte = pbyte;

			if (k == MAX_PATTERN_BYTES - 1) begin : g_head
				assign din = s_tdata;
			end else begin : g_body
				assign din = cell_q[k+1];
			end

			wbps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.clear  (s_tlast),
				.din    (din),
				.ctl    (cell_ctl[k]),
				.dout   (cell_q[k]),
				.hit    (cell_hit[k])
			);
		end
	endgenerate

	assign accept      = s_tvalid && s_tready;
	assign s_tready    = !q_full;
	assign pos_next    = (pos_q == '1) ? pos_q : pos_q + OFFSET_BITS'(1);
	assign window_full = (pos_next >= OFFSET_BITS'(eff_len));
	assign off_diff    = pos_next - OFFSET_BITS'(eff_len);
	assign off_wide    = WIDE_W'(off_diff);
	assign found_now   = !rep_q && window_full && (&cell_hit);
	assign push        = accept && (found_now || (s_tlast && !rep_q));

	assign push_data.found        = found_now;
	assign push_data.match_offset = found_now ? off_wide[MATCH_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rep_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q <= '0;
				rep_q <= 1'b0;
			end else begin
				pos_q <= pos_next;
				if (found_now) rep_q <= 1'b1;
			end
		end
	end

	wbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_data    (m_data)
	);

	assign m_tdata = m_data.match_offset;
	assign m_tuser = m_data.found;

	`WBPS_ASSERT(a_last_clears, clk, arst_n, accept && s_tlast |=> pos_q == '0 && !rep_q, "scan state not cleared after last byte")
	`WBPS_ASSERT(a_match_sticks, clk, arst_n, push && found_now && !s_tlast |=> rep_q, "match not recorded")
	`WBPS_NEVER(a_single_result, clk, arst_n, push && rep_q, "second result in one region")

endmodule
